### hdl/bom_pkg.sv
// Package: shared constants and types for the batch order matcher.
package bom_pkg;
    localparam int MAX_BUYS_DEF  = 16;
    localparam int MAX_SELLS_DEF = 16;
    localparam int ID_BITS_DEF   = 16;
    localparam int RES_W         = 16;
    localparam int QTY_W         = 32;
    localparam int PRICE_W       = 32;
    localparam int MAX_TRADES    = 31;

    typedef enum logic [1:0] {
        REQ_BUY   = 2'd0,
        REQ_SELL  = 2'd1,
        REQ_MATCH = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // One result beat towards the output register.
    typedef struct packed {
        logic                 kind;
        logic [RES_W-1:0]     trade_resource;
        logic [QTY_W-1:0]     trade_quantity;
        logic [PRICE_W-1:0]   exec_price;
        logic [63:0]          trade_value;
        logic [35:0]          sum_quantity;
        logic [63:0]          sum_value;
        logic [4:0]           ignored_buys;
        logic [4:0]           ignored_sells;
        logic [7:0]           dropped_loads;
        logic                 last;
    } t_result;
endpackage

### hdl/bom_mul.sv
// Shift-add multiplier: 32 x 32 product, four bits a cycle.
module bom_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bom_pkg::QTY_W-1:0]  i_a,
    input  logic [bom_pkg::PRICE_W-1:0] i_b,
    output logic                       o_done,
    output logic [63:0]                o_product
);
    import bom_pkg::*;

    logic [QTY_W-1:0] r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_acc;
    logic [3:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [63:0]      n_acc;

    // add four shifted partial products
    always_comb begin
        n_acc = r_acc;
        for (int k = 0; k < 4; k++) begin
            if (r_a[k]) n_acc = n_acc + (r_b << k);
        end
    end

    // step the accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= {32'd0, i_b};
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= r_a >> 4;
                r_b   <= r_b << 4;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;
endmodule

### hdl/batch_order_matcher.sv
// Top level: batch order matcher with stores, ranking sort and matching sequencer.
//
// Channel   Direction  Handshake              Fields
// request   in         start & !busy          req_type, resource, quantity, price_cap
// result    out        o_valid (one cycle)    kind .. last
//
// A load is taken in the idle state. A match scans each store for valid entries, then sorts
// each store with compare-swap and insertion steps, then walks the sell ranks for each
// ranked buy; each trade runs the serial multiplier and is then booked. A summary result
// ends the match; each result shows in the cycle after it is formed.
// Reset is synchronous and active low; it clears counts and the sequencer.
// The receiver cannot stall: each result is shown for exactly one cycle.
module batch_order_matcher #(
    parameter int MAX_BUYS  = bom_pkg::MAX_BUYS_DEF,
    parameter int MAX_SELLS = bom_pkg::MAX_SELLS_DEF,
    parameter int ID_BITS   = bom_pkg::ID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_req_type,
    input  logic [bom_pkg::RES_W-1:0]   i_resource,
    input  logic [bom_pkg::QTY_W-1:0]   i_quantity,
    input  logic [bom_pkg::PRICE_W-1:0] i_price_cap,
    output logic                        o_valid,
    output logic                        o_kind,
    output logic [bom_pkg::RES_W-1:0]   o_trade_resource,
    output logic [bom_pkg::QTY_W-1:0]   o_trade_quantity,
    output logic [bom_pkg::PRICE_W-1:0] o_exec_price,
    output logic [63:0]                 o_trade_value,
    output logic [35:0]                 o_sum_quantity,
    output logic [63:0]                 o_sum_value,
    output logic [4:0]                  o_ignored_buys,
    output logic [4:0]                  o_ignored_sells,
    output logic [7:0]                  o_dropped_loads,
    output logic                        o_last
);
    import bom_pkg::*;

    localparam int BW  = $clog2(MAX_BUYS + 1);
    localparam int SW  = $clog2(MAX_SELLS + 1);
    localparam int BIW = (MAX_BUYS > 1) ? $clog2(MAX_BUYS) : 1;
    localparam int SIW = (MAX_SELLS > 1) ? $clog2(MAX_SELLS) : 1;
    localparam int NMAX = (MAX_BUYS > MAX_SELLS) ? MAX_BUYS : MAX_SELLS;
    localparam int IW  = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int CW  = IW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SORT, S_PAIR, S_MUL, S_EMIT, S_SUM
    } t_state;

    // order stores: flip-flops, each entry read via index registers
    logic [RES_W-1:0]   r_bres [MAX_BUYS];
    logic [QTY_W-1:0]   r_bqty [MAX_BUYS];
    logic [PRICE_W-1:0] r_bprc [MAX_BUYS];
    logic [RES_W-1:0]   r_sres [MAX_SELLS];
    logic [QTY_W-1:0]   r_sqty [MAX_SELLS];
    logic [PRICE_W-1:0] r_sprc [MAX_SELLS];
    logic [BIW-1:0]     r_bidx [MAX_BUYS];
    logic [SIW-1:0]     r_sidx [MAX_SELLS];

    logic [BW-1:0] r_bcnt;
    logic [SW-1:0] r_scnt;
    logic [7:0]    r_drop;
    logic [BW-1:0] r_nb;
    logic [SW-1:0] r_ns;
    logic [4:0]    r_ign_b;
    logic [4:0]    r_ign_s;
    logic [35:0]   r_sumq;
    logic [63:0]   r_sumv;
    logic [5:0]    r_nres;
    t_state        r_state;
    logic          r_side;     // 0 buys, 1 sells
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [QTY_W-1:0] r_tq;
    logic [PRICE_W-1:0] r_tp;
    logic [RES_W-1:0] r_tr;
    t_result       r_out;
    logic          r_out_v;
    logic          r_mstart;
    logic          mul_done;
    logic [63:0]   mul_p;

    logic [RES_W-1:0] id_mask;
    assign id_mask = (ID_BITS >= RES_W) ? {RES_W{1'b1}} : RES_W'((32'd1 << ID_BITS) - 32'd1);

    // shared comparator operands
    logic [PRICE_W-1:0] pa, pb;
    logic [RES_W-1:0]   ra, rb;
    logic               a_first;
    logic [BIW-1:0]     bja, bjb;
    logic [SIW-1:0]     sja, sjb;
    logic [BIW-1:0]     cb;
    logic [SIW-1:0]     cs;

    always_comb begin
        bja = r_bidx[BIW'(r_j)];
        bjb = r_bidx[BIW'(r_j - CW'(1))];
        sja = r_sidx[SIW'(r_j)];
        sjb = r_sidx[SIW'(r_j - CW'(1))];
        if (!r_side) begin
            pa = r_bprc[bja]; ra = r_bres[bja];
            pb = r_bprc[bjb]; rb = r_bres[bjb];
            a_first = (pa != pb) ? (pa > pb) : (ra < rb);
        end else begin
            pa = r_sprc[sja]; ra = r_sres[sja];
            pb = r_sprc[sjb]; rb = r_sres[sjb];
            a_first = (pa != pb) ? (pa < pb) : (ra < rb);
        end
        cb = r_bidx[BIW'(r_i)];
        cs = r_sidx[SIW'(r_j)];
    end

    logic bvalid, svalid;
    assign bvalid = (r_bres[BIW'(r_i)] != '0) && (r_bqty[BIW'(r_i)] != '0)
                  && (r_bprc[BIW'(r_i)] != '0);
    assign svalid = (r_sres[SIW'(r_i)] != '0) && (r_sqty[SIW'(r_i)] != '0)
                  && (r_sprc[SIW'(r_i)] != '0);

    bom_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mstart),
        .i_a       (r_tq),
        .i_b       (r_tp),
        .o_done    (mul_done),
        .o_product (mul_p)
    );

    assign busy = (r_state != S_IDLE);

    // sequencer: load, scan, sort, pair walk, multiply, emit, summary
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bcnt   <= '0;
            r_scnt   <= '0;
            r_drop   <= '0;
            r_out_v  <= 1'b0;
            r_mstart <= 1'b0;
        end else begin
            r_out_v  <= 1'b0;
            r_mstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        unique case (t_req'(i_req_type))
                            REQ_BUY: begin
                                if (r_bcnt >= BW'(MAX_BUYS)) begin
                                    if (r_drop != 8'hFF) r_drop <= r_drop + 8'd1;
                                end else begin
                                    r_bres[BIW'(r_bcnt)] <= i_resource & id_mask;
                                    r_bqty[BIW'(r_bcnt)] <= i_quantity;
                                    r_bprc[BIW'(r_bcnt)] <= i_price_cap;
                                    r_bcnt <= r_bcnt + BW'(1);
                                end
                            end
                            REQ_SELL: begin
                                if (r_scnt >= SW'(MAX_SELLS)) begin
                                    if (r_drop != 8'hFF) r_drop <= r_drop + 8'd1;
                                end else begin
                                    r_sres[SIW'(r_scnt)] <= i_resource & id_mask;
                                    r_sqty[SIW'(r_scnt)] <= i_quantity;
                                    r_sprc[SIW'(r_scnt)] <= i_price_cap;
                                    r_scnt <= r_scnt + SW'(1);
                                end
                            end
                            REQ_MATCH: begin
                                r_state <= S_SCAN;
                                r_side  <= 1'b0;
                                r_i     <= '0;
                                r_nb    <= '0;
                                r_ns    <= '0;
                                r_ign_b <= '0;
                                r_ign_s <= '0;
                                r_sumq  <= '0;
                                r_sumv  <= '0;
                                r_nres  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                // collect valid indices, count invalid ones
                S_SCAN: begin
                    if (!r_side) begin
                        if (r_i >= CW'(r_bcnt)) begin
                            r_side <= 1'b1;
                            r_i    <= '0;
                        end else begin
                            if (bvalid) begin
                                r_bidx[BIW'(r_nb)] <= BIW'(r_i);
                                r_nb <= r_nb + BW'(1);
                            end else begin
                                r_ign_b <= r_ign_b + 5'd1;
                            end
                            r_i <= r_i + CW'(1);
                        end
                    end else begin
                        if (r_i >= CW'(r_scnt)) begin
                            r_state <= S_SORT;
                            r_side  <= 1'b0;
                            r_i     <= CW'(1);
                            r_j     <= CW'(1);
                        end else begin
                            if (svalid) begin
                                r_sidx[SIW'(r_ns)] <= SIW'(r_i);
                                r_ns <= r_ns + SW'(1);
                            end else begin
                                r_ign_s <= r_ign_s + 5'd1;
                            end
                            r_i <= r_i + CW'(1);
                        end
                    end
                end
                // stable insertion sort, one compare-swap a cycle
                S_SORT: begin
                    if (r_i >= (r_side ? CW'(r_ns) : CW'(r_nb))) begin
                        if (!r_side) begin
                            r_side <= 1'b1;
                            r_i    <= CW'(1);
                            r_j    <= CW'(1);
                        end else begin
                            r_state <= S_PAIR;
                            r_i     <= '0;
                            r_j     <= '0;
                        end
                    end else if (r_j != '0 && a_first) begin
                        if (!r_side) begin
                            r_bidx[BIW'(r_j)]          <= bjb;
                            r_bidx[BIW'(r_j - CW'(1))] <= bja;
                        end else begin
                            r_sidx[SIW'(r_j)]          <= sjb;
                            r_sidx[SIW'(r_j - CW'(1))] <= sja;
                        end
                        r_j <= r_j - CW'(1);
                    end else begin
                        r_i <= r_i + CW'(1);
                        r_j <= r_i + CW'(1);
                    end
                end
                // walk buy x sell pairs in rank order
                S_PAIR: begin
                    if (r_i >= CW'(r_nb)) begin
                        r_state <= S_SUM;
                    end else if (r_j >= CW'(r_ns) || r_bqty[cb] == '0) begin
                        r_i <= r_i + CW'(1);
                        r_j <= '0;
                    end else if (r_sqty[cs] != '0 && r_bres[cb] == r_sres[cs]
                                 && r_bprc[cb] >= r_sprc[cs]) begin
                        r_tq <= (r_bqty[cb] < r_sqty[cs]) ? r_bqty[cb] : r_sqty[cs];
                        r_tp <= r_sprc[cs];
                        r_tr <= r_bres[cb];
                        r_mstart <= 1'b1;
                        r_state  <= S_MUL;
                    end else begin
                        r_j <= r_j + CW'(1);
                    end
                end
                S_MUL: begin
                    if (mul_done) r_state <= S_EMIT;
                end
                // book the trade; show it only while fewer than MAX_TRADES trades have been shown
                S_EMIT: begin
                    r_bqty[cb] <= r_bqty[cb] - r_tq;
                    r_sqty[cs] <= r_sqty[cs] - r_tq;
                    r_sumq <= r_sumq + 36'(r_tq);
                    r_sumv <= r_sumv + mul_p;
                    if (r_nres < 6'(MAX_TRADES)) begin
                        r_nres  <= r_nres + 6'd1;
                        r_out_v <= 1'b1;
                        r_out   <= '{kind: 1'b0, trade_resource: r_tr, trade_quantity: r_tq,
                                     exec_price: r_tp, trade_value: mul_p,
                                     default: '0};
                    end
                    r_j     <= r_j + CW'(1);
                    r_state <= S_PAIR;
                end
                S_SUM: begin
                    r_out_v <= 1'b1;
                    r_out   <= '{kind: 1'b1, sum_quantity: r_sumq, sum_value: r_sumv,
                                 ignored_buys: r_ign_b, ignored_sells: r_ign_s,
                                 dropped_loads: r_drop, last: 1'b1, default: '0};
                    r_bcnt  <= '0;
                    r_scnt  <= '0;
                    r_drop  <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_v;
    assign o_kind           = r_out.kind;
    assign o_trade_resource = r_out.trade_resource;
    assign o_trade_quantity = r_out.trade_quantity;
    assign o_exec_price     = r_out.exec_price;
    assign o_trade_value    = r_out.trade_value;
    assign o_sum_quantity   = r_out.sum_quantity;
    assign o_sum_value      = r_out.sum_value;
    assign o_ignored_buys   = r_out.ignored_buys;
    assign o_ignored_sells  = r_out.ignored_sells;
    assign o_dropped_loads  = r_out.dropped_loads;
    assign o_last           = r_out.last;

`ifndef SYNTHESIS
    // summary closes the run and returns the block to idle
    a_sum_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=> (!busy && o_valid && o_last))
        else $error("summary did not end the run");
    // stores never exceed capacity
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bcnt <= BW'(MAX_BUYS)) && (r_scnt <= SW'(MAX_SELLS)))
        else $error("store count beyond capacity");
    // a trade item never carries last
    a_trade_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_kind) |-> !o_last)
        else $error("trade item marked last");
`endif
endmodule
